// ===== hdl/ternary_layer_compositor_macros.svh =====
// -----------------------------------------------------------------------------
// Ternary layer compositor assertion macros
// Shared property shorthands for the compositor checks.
// -----------------------------------------------------------------------------
`ifndef TERNARY_LAYER_COMPOSITOR_MACROS_SVH
`define TERNARY_LAYER_COMPOSITOR_MACROS_SVH

// same-cycle implication
`define TLC_CHK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLC_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tlc_pkg.sv =====
// -----------------------------------------------------------------------------
// Ternary layer compositor package
// Command codes, decoded request and pixel types, trit helpers.
// -----------------------------------------------------------------------------
package tlc_pkg;

	typedef enum logic [2:0] {
		FN_CREATE  = 3'd0,
		FN_DESTROY = 3'd1,
		FN_MOVE    = 3'd2,
		FN_SHOW    = 3'd3,
		FN_WRITE   = 3'd4,
		FN_COMP    = 3'd5,
		FN_READ    = 3'd6,
		FN_BAD     = 3'd7
	} op_t;

	typedef struct packed {
		logic signed [1:0] b;
		logic signed [1:0] g;
		logic signed [1:0] r;
	} pix_t;

	localparam pix_t PIX_BLACK = '{b: 2'sb11, g: 2'sb11, r: 2'sb11};
	localparam pix_t PIX_GRAY  = '{b: 2'sb00, g: 2'sb00, r: 2'sb00};
	localparam logic signed [1:0] RANK_LO = 2'sb11;
	localparam logic signed [1:0] RANK_HI = 2'sb01;
	// coordinate sums: 11-bit origin plus up to 1024 offset
	localparam int CW = 13;

	typedef struct packed {
		op_t               op;
		logic [3:0]        win_id;
		logic signed [10:0] pos_x;
		logic signed [10:0] pos_y;
		logic signed [10:0] size_w;
		logic signed [10:0] size_h;
		logic signed [1:0] layer;
		logic              show;
		pix_t              px;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} cmd_req_t;

	function automatic logic signed [1:0] trit_sat(input logic signed [1:0] t);
		return (t == 2'sb10) ? 2'sb11 : t;
	endfunction

	function automatic logic signed [1:0] tmax(input logic signed [1:0] a,
			input logic signed [1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t pix_max(input pix_t a, input pix_t b);
		pix_t o;
		o.r = tmax(a.r, b.r);
		o.g = tmax(a.g, b.g);
		o.b = tmax(a.b, b.b);
		return o;
	endfunction

endpackage

// ===== hdl/tlc_front.sv =====
// -----------------------------------------------------------------------------
// Compositor front end
// Accepts stream requests, decodes the command and sanitizes its operands.
// -----------------------------------------------------------------------------
module tlc_front import tlc_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        q_full,
	input  logic        init_done,
	output logic        push,
	output cmd_t        cmd
);

	logic signed [10:0] sw, sh;

	assign s_tready = init_done && !q_full;
	assign push     = s_tvalid && s_tready;
	assign sw       = s_tdata[36:26];
	assign sh       = s_tdata[47:37];

	always_comb begin
		cmd.win_id = s_tdata[3:0];
		cmd.pos_x  = s_tdata[14:4];
		cmd.pos_y  = s_tdata[25:15];
		cmd.size_w = sw;
		cmd.size_h = sh;
		cmd.layer  = s_tdata[49:48];
		cmd.show   = s_tdata[50];
		cmd.px.r   = trit_sat(s_tdata[52:51]);
		cmd.px.g   = trit_sat(s_tdata[54:53]);
		cmd.px.b   = trit_sat(s_tdata[56:55]);
		case (s_tuser)
			FN_CREATE:  cmd.op = (sw > 11'sd0 && sh > 11'sd0) ? FN_CREATE : FN_BAD;
			FN_DESTROY: cmd.op = FN_DESTROY;
			FN_MOVE:    cmd.op = FN_MOVE;
			FN_SHOW:    cmd.op = FN_SHOW;
			FN_WRITE:   cmd.op = FN_WRITE;
			FN_COMP:    cmd.op = FN_COMP;
			FN_READ:    cmd.op = FN_READ;
			default:    cmd.op = FN_BAD;
		endcase
	end

endmodule

// ===== hdl/tlc_fifo.sv =====
// -----------------------------------------------------------------------------
// Compositor request queue
// Two-entry queue between the front end and the execution engine.
// -----------------------------------------------------------------------------
module tlc_fifo import tlc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cmd_t     din,
	output logic     full,
	input  logic     pop,
	output cmd_req_t head
);

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign head.vld = (cnt_q != 2'd0);
	assign head.cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/tlc_back.sv =====
// -----------------------------------------------------------------------------
// Compositor execution engine
// Runs one request at a time against the window table, the layer pixel
// memory and the framebuffer memory; holds the result register.
// -----------------------------------------------------------------------------
module tlc_back import tlc_pkg::*; #(
	parameter int FB_WIDTH    = 64,
	parameter int FB_HEIGHT   = 32,
	parameter int MAX_WINDOWS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_req_t    head,
	output logic        pop,
	output logic        init_done,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	localparam int FB_PIXELS = FB_WIDTH * FB_HEIGHT;
	localparam int FA = $clog2(FB_PIXELS);
	localparam int LA = $clog2(MAX_WINDOWS * FB_PIXELS);
	localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int WW = $clog2(FB_WIDTH + 1);
	localparam int HW = $clog2(FB_HEIGHT + 1);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_EXEC, ST_FILL, ST_CLR,
		ST_SCAN, ST_PRD, ST_PWR, ST_RDONE
	} state_t;

	state_t state_q;

	// window table
	logic                 used_q  [MAX_WINDOWS];
	logic                 shown_q [MAX_WINDOWS];
	logic signed [10:0]   ox_q    [MAX_WINDOWS];
	logic signed [10:0]   oy_q    [MAX_WINDOWS];
	logic [WW-1:0]        w_q     [MAX_WINDOWS];
	logic [HW-1:0]        h_q     [MAX_WINDOWS];
	logic signed [1:0]    rank_q  [MAX_WINDOWS];

	pix_t fb_mem  [FB_PIXELS];
	pix_t lay_mem [MAX_WINDOWS * FB_PIXELS];

	cmd_t              cmd_q;
	logic [FA-1:0]     ctr_q;
	logic [SW-1:0]     scan_q;
	logic signed [1:0] rank_cur_q;
	logic [WW-1:0]     wx_q;
	logic [HW-1:0]     wy_q;
	logic [FA-1:0]     lin_q;
	logic [LA-1:0]     base_q;
	logic [FA-1:0]     fb_waddr_q;
	pix_t              fb_rdata_q, lay_rdata_q;

	logic        out_vld_q, res_err_q;
	logic [3:0]  res_slot_q;
	pix_t        res_px_q;

	// combinational
	logic [SW-1:0]       id_idx, win_idx, free_idx;
	logic                any_free, id_ok, win_match;
	logic [WW-1:0]       w_cur;
	logic [HW-1:0]       h_cur;
	logic                wx_last, px_last, scan_end;
	logic [SW-1:0]       nxt_slot;
	logic signed [CW-1:0] fx, fy;
	logic                fb_inb, rd_inb, wr_inb;
	logic [FA-1:0]       walk_addr, rd_addr, fb_raddr, fb_waddr;
	logic [LA-1:0]       lay_raddr, lay_waddr;
	logic                fb_we, lay_we;
	pix_t                fb_wdata, lay_wdata;
	logic [WW-1:0]       clamp_w;
	logic [HW-1:0]       clamp_h;

	assign id_idx  = SW'(cmd_q.win_id);
	assign win_idx = (state_q == ST_EXEC) ? id_idx : scan_q;
	assign id_ok   = (int'(cmd_q.win_id) < MAX_WINDOWS) && used_q[id_idx];
	assign w_cur   = w_q[win_idx];
	assign h_cur   = h_q[win_idx];
	assign win_match = used_q[win_idx] && shown_q[win_idx] &&
		(rank_q[win_idx] == rank_cur_q);

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				any_free = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign clamp_w = (int'(cmd_q.size_w) > FB_WIDTH) ? WW'(FB_WIDTH) : WW'(cmd_q.size_w);
	assign clamp_h = (int'(cmd_q.size_h) > FB_HEIGHT) ? HW'(FB_HEIGHT) : HW'(cmd_q.size_h);

	// pixel walker
	assign wx_last  = (wx_q == w_cur - 1'b1);
	assign px_last  = wx_last && (wy_q == h_cur - 1'b1);
	assign scan_end = (scan_q == SW'(MAX_WINDOWS - 1)) && (rank_cur_q == RANK_HI);
	assign nxt_slot = (scan_q == SW'(MAX_WINDOWS - 1)) ? '0 : scan_q + 1'b1;

	assign fx = CW'(ox_q[win_idx]) + CW'(wx_q);
	assign fy = CW'(oy_q[win_idx]) + CW'(wy_q);
	assign fb_inb = (fx >= 0) && (fx < CW'(FB_WIDTH)) && (fy >= 0) && (fy < CW'(FB_HEIGHT));
	assign walk_addr = FA'(FA'($unsigned(fy)) * FA'(FB_WIDTH) + FA'($unsigned(fx)));

	assign rd_inb = (cmd_q.pos_x >= 0) && (int'(cmd_q.pos_x) < FB_WIDTH) &&
		(cmd_q.pos_y >= 0) && (int'(cmd_q.pos_y) < FB_HEIGHT);
	assign rd_addr = FA'(FA'($unsigned(cmd_q.pos_y)) * FA'(FB_WIDTH) +
		FA'($unsigned(cmd_q.pos_x)));
	assign wr_inb = id_ok && (cmd_q.pos_x >= 0) && (int'(cmd_q.pos_x) < int'(w_cur)) &&
		(cmd_q.pos_y >= 0) && (int'(cmd_q.pos_y) < int'(h_cur));

	always_comb begin
		fb_raddr  = (state_q == ST_EXEC) ? rd_addr : walk_addr;
		lay_raddr = base_q + LA'(lin_q);
		fb_we     = 1'b0;
		fb_waddr  = ctr_q;
		fb_wdata  = PIX_BLACK;
		lay_we    = 1'b0;
		lay_waddr = base_q + LA'(lin_q);
		lay_wdata = PIX_GRAY;
		case (state_q)
			ST_INIT, ST_CLR: fb_we = 1'b1;
			ST_PWR: begin
				fb_we    = 1'b1;
				fb_waddr = fb_waddr_q;
				fb_wdata = pix_max(fb_rdata_q, lay_rdata_q);
			end
			ST_FILL: lay_we = 1'b1;
			ST_EXEC: begin
				if (cmd_q.op == FN_WRITE && wr_inb) begin
					lay_we    = 1'b1;
					lay_waddr = LA'(LA'(id_idx) * LA'(FB_PIXELS) +
						LA'($unsigned(cmd_q.pos_y)) * LA'(w_cur) +
						LA'($unsigned(cmd_q.pos_x)));
					lay_wdata = cmd_q.px;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
		fb_rdata_q <= fb_mem[fb_raddr];
	end

	always_ff @(posedge clk) begin
		if (lay_we) lay_mem[lay_waddr] <= lay_wdata;
		lay_rdata_q <= lay_mem[lay_raddr];
	end

	assign pop       = (state_q == ST_IDLE) && head.vld && (!out_vld_q || m_tready);
	assign init_done = (state_q != ST_INIT);
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {5'd0, res_px_q.b, res_px_q.g, res_px_q.r, res_slot_q, res_err_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			ctr_q      <= '0;
			out_vld_q  <= 1'b0;
			res_err_q  <= 1'b0;
			res_slot_q <= '0;
			res_px_q   <= PIX_GRAY;
			cmd_q      <= '0;
			scan_q     <= '0;
			rank_cur_q <= RANK_LO;
			wx_q       <= '0;
			wy_q       <= '0;
			lin_q      <= '0;
			base_q     <= '0;
			fb_waddr_q <= '0;
			for (int i = 0; i < MAX_WINDOWS; i++) begin
				used_q[i]  <= 1'b0;
				shown_q[i] <= 1'b0;
				ox_q[i]    <= '0;
				oy_q[i]    <= '0;
				w_q[i]     <= '0;
				h_q[i]     <= '0;
				rank_q[i]  <= '0;
			end
		end else begin
			if (out_vld_q && m_tready) out_vld_q <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLR: begin
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == FA'(FB_PIXELS - 1)) begin
						ctr_q <= '0;
						if (state_q == ST_INIT) begin
							state_q <= ST_IDLE;
						end else begin
							scan_q     <= '0;
							rank_cur_q <= RANK_LO;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cmd_q   <= head.cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// default: error result, done
					res_err_q  <= 1'b1;
					res_slot_q <= '0;
					res_px_q   <= PIX_GRAY;
					out_vld_q  <= 1'b1;
					state_q    <= ST_IDLE;
					case (cmd_q.op)
						FN_CREATE: begin
							if (any_free) begin
								used_q[free_idx]  <= 1'b1;
								shown_q[free_idx] <= 1'b1;
								ox_q[free_idx]    <= cmd_q.pos_x;
								oy_q[free_idx]    <= cmd_q.pos_y;
								w_q[free_idx]     <= clamp_w;
								h_q[free_idx]     <= clamp_h;
								rank_q[free_idx]  <= cmd_q.layer;
								scan_q    <= free_idx;
								base_q    <= LA'(LA'(free_idx) * LA'(FB_PIXELS));
								wx_q      <= '0;
								wy_q      <= '0;
								lin_q     <= '0;
								out_vld_q <= 1'b0;
								state_q   <= ST_FILL;
							end
						end
						FN_DESTROY: begin
							if (id_ok) begin
								used_q[id_idx]  <= 1'b0;
								shown_q[id_idx] <= 1'b0;
								res_err_q       <= 1'b0;
							end
						end
						FN_MOVE: begin
							if (id_ok) begin
								ox_q[id_idx] <= cmd_q.pos_x;
								oy_q[id_idx] <= cmd_q.pos_y;
								res_err_q    <= 1'b0;
							end
						end
						FN_SHOW: begin
							if (id_ok) begin
								shown_q[id_idx] <= cmd_q.show;
								res_err_q       <= 1'b0;
							end
						end
						FN_WRITE: res_err_q <= !wr_inb;
						FN_COMP: begin
							out_vld_q <= 1'b0;
							ctr_q     <= '0;
							state_q   <= ST_CLR;
						end
						FN_READ: begin
							if (rd_inb) begin
								out_vld_q <= 1'b0;
								state_q   <= ST_RDONE;
							end else begin
								res_px_q <= PIX_BLACK;
							end
						end
						default: ;
					endcase
				end
				ST_RDONE: begin
					res_err_q <= 1'b0;
					res_px_q  <= fb_rdata_q;
					out_vld_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_FILL: begin
					wx_q  <= wx_last ? '0 : wx_q + 1'b1;
					wy_q  <= wx_last ? wy_q + 1'b1 : wy_q;
					lin_q <= lin_q + 1'b1;
					if (px_last) begin
						res_err_q  <= 1'b0;
						res_slot_q <= 4'(scan_q);
						out_vld_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (win_match) begin
						base_q  <= LA'(LA'(scan_q) * LA'(FB_PIXELS));
						wx_q    <= '0;
						wy_q    <= '0;
						lin_q   <= '0;
						state_q <= ST_PRD;
					end else if (scan_end) begin
						res_err_q <= 1'b0;
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						scan_q <= nxt_slot;
						if (nxt_slot == '0) rank_cur_q <= rank_cur_q + 2'sd1;
					end
				end
				ST_PRD, ST_PWR: begin
					if (state_q == ST_PRD && fb_inb) begin
						// read issued this cycle, merge in the next
						fb_waddr_q <= walk_addr;
						state_q    <= ST_PWR;
					end else begin
						wx_q    <= wx_last ? '0 : wx_q + 1'b1;
						wy_q    <= wx_last ? wy_q + 1'b1 : wy_q;
						lin_q   <= lin_q + 1'b1;
						state_q <= ST_PRD;
						if (px_last) begin
							if (scan_end) begin
								res_err_q <= 1'b0;
								out_vld_q <= 1'b1;
								state_q   <= ST_IDLE;
							end else begin
								scan_q  <= nxt_slot;
								if (nxt_slot == '0) rank_cur_q <= rank_cur_q + 2'sd1;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ternary_layer_compositor.sv =====
// -----------------------------------------------------------------------------
// Ternary layer compositor
// Window layers with trit color channels, merged into a framebuffer.
// -----------------------------------------------------------------------------
// After reset the block clears the framebuffer and takes no request until
// that is done. Requests go through a two-entry queue to a single execution
// engine that works on one request at a time: table updates, layer pixel
// writes and failing requests give their result straight from the execute
// state, framebuffer reads through a further read state. Create also fills
// the new layer with gray at one pixel a cycle. Composite clears the
// framebuffer, scans 3*MAX_WINDOWS slot/priority pairs, and for each layer
// pixel that lands on the framebuffer reads it and then writes back the
// merged pixel (read-merge-write); other pixels are only stepped past.
`include "ternary_layer_compositor_macros.svh"

module ternary_layer_compositor import tlc_pkg::*; #(
	parameter int FB_WIDTH    = 64,
	parameter int FB_HEIGHT   = 32,
	parameter int MAX_WINDOWS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// win_id, pos_x, pos_y, size_w, size_h, layer, show, chan_r, chan_g, chan_b
	input  logic [63:0] s_tdata,
	// func
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, slot, out_r, out_g, out_b
	output logic [15:0] m_tdata
);

	logic     push, q_full, pop, init_done;
	cmd_t     cmd;
	cmd_req_t head;

	tlc_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.init_done(init_done),
		.push     (push),
		.cmd      (cmd)
	);

	tlc_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd),
		.full  (q_full),
		.pop   (pop),
		.head  (head)
	);

	tlc_back #(
		.FB_WIDTH   (FB_WIDTH),
		.FB_HEIGHT  (FB_HEIGHT),
		.MAX_WINDOWS(MAX_WINDOWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.init_done(init_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`TLC_CHK(a_accept_after_init, s_tvalid && s_tready, init_done, "request during fb clear")
	`TLC_CHK(a_push_not_full, push, !q_full, "queue overflow")
	`TLC_CHK(a_pop_out_free, pop, head.vld && (!m_tvalid || m_tready), "pop with result pending")
	`TLC_CHK_NEXT(a_pop_single, pop, !pop, "back popped on consecutive cycles")

endmodule
